@@ hw/rtl/als_pkg.sv @@
// Shared types and codes for the array list insert and search block.
`default_nettype none
package als_pkg;

   localparam logic [2:0] OP_PUSH   = 3'd0;
   localparam logic [2:0] OP_INSERT = 3'd1;
   localparam logic [2:0] OP_GET    = 3'd2;
   localparam logic [2:0] OP_LOCATE = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;

   localparam logic [4:0] NOT_FOUND = 5'h1F;

   typedef struct packed {
      logic        push_en;
      logic        insert_en;
      logic [3:0]  pos;
      logic [31:0] value;
   } write_type;

   typedef struct packed {
      logic        get_en;
      logic        locate_en;
      logic [3:0]  pos;
      logic [31:0] value;
   } search_type;

   typedef struct packed {
      logic        hit;
      logic [4:0]  index;
      logic [31:0] data;
   } carry_type;

endpackage
`default_nettype wire

@@ hw/rtl/array_list_insert_search_top.sv @@
// Top level of the array list insert and search block: control and the row of cells.
// One request is taken at a time. Push and insert write the cells, and clear empties the list,
// in the beat's accept cycle; every request then waits for the search wavefront to cross all
// CAPACITY cells, so the response is valid once the wavefront leaves the last cell, and the
// next request is taken only after the response beat has been taken. Synchronous reset
// empties the list; entries are kept.
`default_nettype none
module array_list_insert_search_top #(
   parameter int CAPACITY = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,  // position [3:0], value [35:4], zero pad [39:36]
   input  wire  [2:0]  req_tuser,  // op [2:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [47:0] rsp_tdata   // read_value [31:0], found_index [36:32], count [41:37],
                                   // empty_res [42], status [44:43], zero pad [47:45]
);

   localparam int FW = $clog2(CAPACITY + 1);
   localparam int CW = $clog2(CAPACITY);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [FW-1:0]        fill_ff, fill_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [1:0]           status_ff, status_in;
   als_pkg::search_type  search_ff, search_in;
   als_pkg::write_type   wr_cmd;
   logic                 accept;
   logic [2:0]           op;
   logic [3:0]           pos;
   logic [31:0]          value;
   logic                 full;
   logic [31:0]          entries [CAPACITY];
   als_pkg::carry_type   carries [CAPACITY];
   als_pkg::carry_type   last;
   logic [31:0]          read_value;
   logic [4:0]           found_index;

   assign op     = req_tuser;
   assign pos    = req_tdata[3:0];
   assign value  = req_tdata[35:4];
   assign accept = req_tvalid && req_tready;
   assign full   = (32'(fill_ff) >= 32'(CAPACITY));

   always_comb begin
      fill_in          = fill_ff;
      status_in        = status_ff;
      search_in        = search_ff;
      wr_cmd.push_en   = 1'b0;
      wr_cmd.insert_en = 1'b0;
      wr_cmd.pos       = pos;
      wr_cmd.value     = value;
      if (accept) begin
         status_in           = als_pkg::STAT_OK;
         search_in.get_en    = 1'b0;
         search_in.locate_en = 1'b0;
         search_in.pos       = pos;
         search_in.value     = value;
         case (op)
            als_pkg::OP_PUSH: begin
               if (full) begin
                  status_in = als_pkg::STAT_FULL;
               end else begin
                  wr_cmd.push_en = 1'b1;
                  fill_in        = fill_ff + 1'b1;
               end
            end
            als_pkg::OP_INSERT: begin
               if (full) begin
                  status_in = als_pkg::STAT_FULL;
               end else if (32'(pos) > 32'(fill_ff)) begin
                  status_in = als_pkg::STAT_RANGE;
               end else begin
                  wr_cmd.insert_en = 1'b1;
                  fill_in          = fill_ff + 1'b1;
               end
            end
            als_pkg::OP_GET: begin
               if (32'(pos) >= 32'(fill_ff)) begin
                  status_in = als_pkg::STAT_RANGE;
               end else begin
                  search_in.get_en = 1'b1;
               end
            end
            als_pkg::OP_LOCATE: begin
               search_in.locate_en = 1'b1;
            end
            als_pkg::OP_CLEAR: begin
               fill_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(CAPACITY - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         cnt_ff    <= '0;
         status_ff <= als_pkg::STAT_OK;
         search_ff <= '0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         cnt_ff    <= cnt_in;
         status_ff <= status_in;
         search_ff <= search_in;
      end
   end

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      als_pkg::carry_type carry_src;
      logic [31:0]        left_src;
      if (k == 0) begin : g_first
         assign carry_src = '{hit: 1'b0, index: als_pkg::NOT_FOUND, data: 32'd0};
         assign left_src  = '0;
      end else begin : g_rest
         assign carry_src = carries[k-1];
         assign left_src  = entries[k-1];
      end
      als_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .wr_cmd     (wr_cmd),
         .search     (search_ff),
         .fill       (fill_ff),
         .left_entry (left_src),
         .entry      (entries[k]),
         .carry_in   (carry_src),
         .carry_out  (carries[k])
      );
   end

   assign last = carries[CAPACITY-1];

   always_comb begin
      read_value  = '0;
      found_index = als_pkg::NOT_FOUND;
      if (search_ff.get_en && last.hit) begin
         read_value = last.data;
      end
      if (search_ff.locate_en && last.hit) begin
         found_index = last.index;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_DONE);
   assign rsp_tdata  = {3'd0, status_ff, (fill_ff == '0), 5'(fill_ff), found_index,
                        read_value};

endmodule
`default_nettype wire

@@ hw/rtl/als_cell.sv @@
// One list cell: holds one entry and passes the search wavefront to its neighbor.
`default_nettype none
module als_cell #(
   parameter int CAPACITY = 16,
   parameter int INDEX    = 0
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire als_pkg::write_type          wr_cmd,
   input  wire als_pkg::search_type         search,
   input  wire [$clog2(CAPACITY+1)-1:0]     fill,
   input  wire [31:0]                       left_entry,
   output logic [31:0]                      entry,
   input  wire als_pkg::carry_type          carry_in,
   output als_pkg::carry_type               carry_out
);

   localparam int FW = $clog2(CAPACITY + 1);
   localparam logic [FW-1:0] K = FW'(INDEX);

   logic [31:0]        entry_ff;
   logic [31:0]        entry_in;
   logic               entry_we;
   als_pkg::carry_type carry_ff;
   als_pkg::carry_type carry_in_next;
   logic               at_pos;
   logic               above_pos;
   logic               live;

   assign at_pos    = ({28'd0, search.pos} == 32'(INDEX)) && 1'b1;
   assign above_pos = (32'(INDEX) > {28'd0, wr_cmd.pos});
   assign live      = (K < fill);

   always_comb begin
      entry_we = 1'b0;
      entry_in = wr_cmd.value;
      if (wr_cmd.push_en && (K == fill)) begin
         entry_we = 1'b1;
      end else if (wr_cmd.insert_en) begin
         if ({28'd0, wr_cmd.pos} == 32'(INDEX)) begin
            entry_we = 1'b1;
         end else if (above_pos && (K <= fill)) begin
            entry_we = 1'b1;
            entry_in = left_entry;
         end
      end
   end

   always_comb begin
      carry_in_next = carry_in;
      if (!carry_in.hit && live) begin
         if (search.get_en && at_pos) begin
            carry_in_next.hit  = 1'b1;
            carry_in_next.data = entry_ff;
         end else if (search.locate_en && (entry_ff == search.value)) begin
            carry_in_next.hit   = 1'b1;
            carry_in_next.index = 5'(INDEX);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (entry_we) begin
         entry_ff <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= '0;
      end else begin
         carry_ff <= carry_in_next;
      end
   end

   assign entry     = entry_ff;
   assign carry_out = carry_ff;

endmodule
`default_nettype wire
